### rtl/cbm_pkg.sv
package cbm_pkg;

  localparam int unsigned PrgW  = 22;
  localparam int unsigned ChrW  = 19;
  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;

  localparam logic [PrgW-1:0] PrgMaskReset = 22'd262143;
  localparam logic [ChrW-1:0] ChrMaskReset = 19'd131071;

  typedef enum logic [1:0] {
    FUNC_CPU_WRITE = 2'd0,
    FUNC_CPU_READ  = 2'd1,
    FUNC_PPU_READ  = 2'd2,
    FUNC_TICK      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_CHR  = 2'd2,
    TGT_RSVD = 2'd3
  } target_e;

  // mapper register select, address bits 14:12
  typedef enum logic [2:0] {
    SEL_CHR0     = 3'd0,
    SEL_CHR1     = 3'd1,
    SEL_CHR2     = 3'd2,
    SEL_CHR3     = 3'd3,
    SEL_IRQ_LOAD = 3'd4,
    SEL_IRQ_CTRL = 3'd5,
    SEL_MIRROR   = 3'd6,
    SEL_PRG      = 3'd7
  } sel_e;

  typedef enum logic {
    REG_PRG_MASK = 1'b0,
    REG_CHR_MASK = 1'b1
  } reg_e;

  typedef struct packed {
    logic [PrgW-1:0] prg_mask;
    logic [ChrW-1:0] chr_mask;
  } cfg_t;

  typedef struct packed {
    func_e            func;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
  } item_t;

  typedef struct packed {
    target_e         target;
    logic [PrgW-1:0] rom_address;
    logic [1:0]      mirror_mode;
    logic            irq_line;
  } result_t;

endpackage

### rtl/cartridge_bank_mapper_irq_top.sv
// Cartridge bank mapper with a 16-bit cycle IRQ counter.
// Input stream: one beat per bus event. s_axis_tuser carries the event kind
// (CPU write, CPU read, video read, CPU clock tick); s_axis_tdata carries the
// bus address and the write byte. Every beat gives exactly one output beat:
// m_axis_tuser says whether tdata holds a PRG or CHR ROM address (or none),
// and tdata also carries the mirroring mode and the IRQ line after the event.
// The APB port holds the PRG and CHR ROM size masks; write them while idle.
// A beat accepted on s_axis is caught in the event register, which feeds the bank
// and IRQ logic; their answer is caught in the output register and shows on m_axis.
// The block takes one beat per cycle while the output is not stalled.
// When the receiver holds m_axis_tready low, the output beat stays and the
// event register fills; s_axis_tready then drops until the output drains.
// Reset clears the pipeline, the banks, the counter and the IRQ state, and
// loads the default ROM size masks (256KB PRG, 128KB CHR).
module cartridge_bank_mapper_irq_top import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] data
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [21:0] rom_address, [23:22] mirror_mode,
                                      // [24] irq_line, [31:25] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] rom_target
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  result_t result;
  item_t   item_q;
  result_t out_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    out_free;
  logic    fire;

  cbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_free)      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.func    <= func_e'(s_axis_tuser);
      item_q.address <= s_axis_tdata[15:0];
      item_q.data    <= s_axis_tdata[23:16];
    end
    if (fire) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.target;
  assign m_axis_tdata  = {7'b0, out_q.irq_line, out_q.mirror_mode, out_q.rom_address};

endmodule

### rtl/cbm_cfg.sv
module cbm_cfg import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [PrgW-1:0] prg_mask_q;
  logic [ChrW-1:0] chr_mask_q;
  logic            wr_en;
  reg_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_mask_q <= PrgMaskReset;
      chr_mask_q <= ChrMaskReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRG_MASK: prg_mask_q <= pwdata[PrgW-1:0];
        REG_CHR_MASK: chr_mask_q <= pwdata[ChrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRG_MASK: prdata = {{(32-PrgW){1'b0}}, prg_mask_q};
      REG_CHR_MASK: prdata = {{(32-ChrW){1'b0}}, chr_mask_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.prg_mask = prg_mask_q;
  assign cfg_o.chr_mask = chr_mask_q;

endmodule

### rtl/cbm_core.sv
module cbm_core import cbm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  // bank bases keep only their page bits
  logic [7:0]  prg_bank_q, prg_bank_d;
  logic [7:0]  chr_bank_q [4];
  logic [7:0]  chr_bank_d [4];
  logic [15:0] counter_q, counter_d;
  logic        enabled_q, enabled_d;
  logic        pending_q, pending_d;
  logic        low_next_q, low_next_d;
  logic [1:0]  mirror_q, mirror_d;

  logic        wr_hit;
  sel_e        sel;
  logic [15:0] addr;
  logic [7:0]  data;

  assign addr   = item_i.address;
  assign data   = item_i.data;
  assign sel    = sel_e'(addr[14:12]);
  assign wr_hit = addr[15] & addr[11];

  always_comb begin
    prg_bank_d = prg_bank_q;
    chr_bank_d = chr_bank_q;
    counter_d  = counter_q;
    enabled_d  = enabled_q;
    pending_d  = pending_q;
    low_next_d = low_next_q;
    mirror_d   = mirror_q;

    result_o.target      = TGT_NONE;
    result_o.rom_address = '0;

    unique case (item_i.func)
      FUNC_CPU_WRITE: begin
        if (wr_hit) begin
          unique case (sel)
            SEL_CHR0, SEL_CHR1, SEL_CHR2, SEL_CHR3:
              chr_bank_d[sel[1:0]] = data & cfg_i.chr_mask[ChrW-1:11];
            SEL_IRQ_LOAD: begin
              if (low_next_q) counter_d = {counter_q[15:8], data};
              else            counter_d = {data, counter_q[7:0]};
              low_next_d = ~low_next_q;
            end
            SEL_IRQ_CTRL: begin
              enabled_d  = data[4];
              low_next_d = 1'b0;
              pending_d  = 1'b0;
            end
            SEL_MIRROR: mirror_d = data[1:0];
            SEL_PRG:    prg_bank_d = data & cfg_i.prg_mask[PrgW-1:14];
            default: ;
          endcase
        end
      end
      FUNC_CPU_READ: begin
        if (addr[15]) begin
          result_o.target = TGT_PRG;
          // upper 16KB is pinned to the last bank of the ROM
          result_o.rom_address = addr[14] ? {cfg_i.prg_mask[PrgW-1:14], addr[13:0]}
                                          : {prg_bank_q, addr[13:0]};
        end
      end
      FUNC_PPU_READ: begin
        if (!addr[13]) begin
          result_o.target      = TGT_CHR;
          result_o.rom_address = {3'b000, chr_bank_q[addr[12:11]], addr[10:0]};
        end
      end
      FUNC_TICK: begin
        if (enabled_q) begin
          if (counter_q == 16'h0000) begin
            pending_d = 1'b1;
            enabled_d = 1'b0;
          end
          counter_d = counter_q - 16'd1;
        end
      end
      default: ;
    endcase

    result_o.mirror_mode = mirror_d;
    result_o.irq_line    = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bank_q <= '0;
      for (int i = 0; i < 4; i++) chr_bank_q[i] <= '0;
      counter_q  <= '0;
      enabled_q  <= 1'b0;
      pending_q  <= 1'b0;
      low_next_q <= 1'b0;
      mirror_q   <= '0;
    end else if (fire_i) begin
      prg_bank_q <= prg_bank_d;
      chr_bank_q <= chr_bank_d;
      counter_q  <= counter_d;
      enabled_q  <= enabled_d;
      pending_q  <= pending_d;
      low_next_q <= low_next_d;
      mirror_q   <= mirror_d;
    end
  end

endmodule

### rtl/cbm_checker.sv
module cbm_checker import cbm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed under stall");

  a_target_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != TGT_RSVD)
    else $error("reserved rom target");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == TGT_NONE |-> m_axis_tdata[21:0] == 22'd0)
    else $error("address not zero without rom target");

  a_chr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == TGT_CHR |-> m_axis_tdata[21:19] == 3'd0)
    else $error("chr address out of range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
    else $error("tdata padding not zero");

endmodule

bind cartridge_bank_mapper_irq_top cbm_checker u_cbm_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import cbm_pkg::*; ();

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [15:0] address, [23:16] data
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [21:0] rom_address, [23:22] mirror_mode, [24] irq_line
  logic [1:0]  m_axis_tuser;        // [1:0] rom_target
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cartridge_bank_mapper_irq_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // mapper shadow state
  logic [PrgW-1:0] prg_size_mask = PrgMaskReset;
  logic [ChrW-1:0] chr_size_mask = ChrMaskReset;
  logic [PrgW-1:0] prg_base = '0;
  logic [ChrW-1:0] chr_base [4] = '{default: '0};
  logic [15:0]     irq_cnt = '0;
  logic            irq_en = 1'b0;
  logic            irq_pend = 1'b0;
  logic            irq_lo_next = 1'b0;
  logic [1:0]      mirror_q = '0;

  item_t   bus_q [$];
  result_t rom_expect_q [$];
  item_t   bus_cur;
  result_t rom_want;
  int      n_err = 0;
  int      n_queued = 0;
  int      n_results = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      hold_left = 0;
  int      idle_cyc = 0;
  logic [7:0] rx_cyc = '0;
  logic    rx_rdy;

  function automatic result_t map_predict(item_t it);
    result_t r;
    sel_e    sel;
    r = '0;
    r.target = TGT_NONE;
    case (it.func)
      FUNC_CPU_WRITE: begin
        if (it.address[15] && it.address[11]) begin
          sel = sel_e'(it.address[14:12]);
          case (sel)
            SEL_CHR0, SEL_CHR1, SEL_CHR2, SEL_CHR3: begin
              chr_base[it.address[13:12]] = {it.data, 11'h0} & chr_size_mask;
            end
            SEL_IRQ_LOAD: begin
              if (irq_lo_next) irq_cnt[7:0] = it.data;
              else irq_cnt[15:8] = it.data;
              irq_lo_next = !irq_lo_next;
            end
            SEL_IRQ_CTRL: begin
              irq_en = it.data[4];
              irq_lo_next = 1'b0;
              irq_pend = 1'b0;
            end
            SEL_MIRROR: mirror_q = it.data[1:0];
            default: prg_base = {it.data, 14'h0} & prg_size_mask;
          endcase
        end
      end
      FUNC_CPU_READ: begin
        if (it.address[15]) begin
          r.target = TGT_PRG;
          // upper window is pinned to the last bank of the ROM
          if (it.address[14]) r.rom_address = {prg_size_mask[PrgW-1:14], it.address[13:0]};
          else r.rom_address = prg_base | {8'h0, it.address[13:0]};
        end
      end
      FUNC_PPU_READ: begin
        if (!it.address[13]) begin
          r.target = TGT_CHR;
          r.rom_address = {3'b0, chr_base[it.address[12:11]] | {8'h0, it.address[10:0]}};
        end
      end
      default: begin
        if (irq_en) begin
          if (irq_cnt == 16'h0) begin
            irq_pend = 1'b1;
            irq_en = 1'b0;
          end
          irq_cnt = irq_cnt - 16'h1;
        end
      end
    endcase
    r.mirror_mode = mirror_q;
    r.irq_line = irq_pend;
    return r;
  endfunction

  function automatic logic [15:0] reg_addr(sel_e s);
    return {1'b1, s, 1'b1, 11'h0};
  endfunction

  task automatic push_bus(func_e f, logic [15:0] a, logic [7:0] d);
    bus_q.push_back('{func: f, address: a, data: d});
    n_queued++;
  endtask

  task automatic push_reg_write(sel_e s, logic [7:0] d);
    push_bus(FUNC_CPU_WRITE, reg_addr(s) | 16'($urandom_range(2047, 0)), d);
  endtask

  task automatic push_random(int n);
    int start;
    int k;
    int kind;
    start = n_queued;
    while (n_queued - start < n) begin
      kind = $urandom_range(9, 0);
      case (kind)
        0, 1, 2: push_bus(FUNC_CPU_READ, 16'($urandom), 8'($urandom));
        3, 4: push_bus(FUNC_PPU_READ, 16'($urandom), 8'($urandom));
        5: push_reg_write(sel_e'($urandom_range(7, 0)), 8'($urandom));
        6: push_bus(FUNC_CPU_WRITE, 16'($urandom), 8'($urandom));
        7: begin
          // full counter setup: ack, high, low, usually enable, then a run of ticks
          push_reg_write(SEL_IRQ_CTRL, 8'($urandom) & 8'hEF);
          push_reg_write(SEL_IRQ_LOAD, ($urandom_range(3, 0) == 0) ? 8'($urandom) : 8'h00);
          push_reg_write(SEL_IRQ_LOAD, 8'($urandom_range(24, 0)));
          push_reg_write(SEL_IRQ_CTRL,
                         ($urandom_range(4, 0) != 0) ? (8'($urandom) | 8'h10) : 8'($urandom));
          k = $urandom_range(30, 0);
          repeat (k) push_bus(FUNC_TICK, 16'($urandom), 8'($urandom));
        end
        default: begin
          k = $urandom_range(8, 1);
          repeat (k) push_bus(FUNC_TICK, 16'($urandom), 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic cfg_write(reg_e idx, logic [31:0] val);
    logic [31:0] want_rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_PRG_MASK) begin
      prg_size_mask = val[PrgW-1:0];
      want_rd = 32'(prg_size_mask);
    end else begin
      chr_size_mask = val[ChrW-1:0];
      want_rd = 32'(chr_size_mask);
    end
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== want_rd) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx, want_rd, prdata);
      n_err++;
    end
  endtask

  task automatic wait_drained();
    while (bus_q.size() != 0 || rom_expect_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_masks(logic [31:0] prg, logic [31:0] chr);
    wait_drained();
    cfg_write(REG_PRG_MASK, prg);
    cfg_write(REG_CHR_MASK, chr);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: bank edges, fixed window, ignored writes, counter underflow
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_PRG), 8'hFF);
    push_bus(FUNC_CPU_READ, 16'h8000, 8'h00);
    push_bus(FUNC_CPU_READ, 16'hBFFF, 8'hFF);
    push_bus(FUNC_CPU_READ, 16'hC000, 8'h00);
    push_bus(FUNC_CPU_READ, 16'hFFFF, 8'h00);
    push_bus(FUNC_CPU_READ, 16'h7FFF, 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_CHR0), 8'hFF);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_CHR3) | 16'h07FF, 8'hAA);
    push_bus(FUNC_PPU_READ, 16'h0000, 8'h00);
    push_bus(FUNC_PPU_READ, 16'h1FFF, 8'h00);
    push_bus(FUNC_PPU_READ, 16'h2000, 8'h00);
    push_bus(FUNC_PPU_READ, 16'hC7FF, 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_MIRROR), 8'hFF);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_PRG) & 16'hF7FF, 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_PRG) & 16'h7FFF, 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_IRQ_CTRL), 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_IRQ_LOAD), 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_IRQ_LOAD), 8'h02);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_IRQ_CTRL), 8'hFF);
    repeat (4) push_bus(FUNC_TICK, 16'hFFFF, 8'hFF);
    push_bus(FUNC_CPU_READ, 16'h8000, 8'h00);
    push_bus(FUNC_CPU_WRITE, reg_addr(SEL_IRQ_CTRL), 8'h00);
    push_random(70);

    set_masks(32'h3FFFFF, 32'h7FFFF);
    push_random(70);
    set_masks(32'h3FFF, 32'h7FF);
    push_random(70);
    set_masks(32'h7FFF, 32'hFFF);
    push_random(70);
    set_masks((32'h1 << $urandom_range(22, 14)) - 1, (32'h1 << $urandom_range(19, 11)) - 1);
    push_random(70);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (n_err == 0 && rom_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // bus event driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rom_expect_q.push_back(map_predict('{func: func_e'(s_axis_tuser),
                                             address: s_axis_tdata[15:0],
                                             data: s_axis_tdata[23:16]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (bus_q.size() != 0) begin
          bus_cur = bus_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {bus_cur.data, bus_cur.address};
          s_axis_tuser  <= bus_cur.func;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 8'd1;
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (n_results == 60 || n_results == 280) hold_left = HoldCycles;
        if (rom_expect_q.size() == 0) begin
          $display("%0t: unexpected beat tuser=%h tdata=%h", $time, m_axis_tuser, m_axis_tdata);
          n_err++;
        end else begin
          rom_want = rom_expect_q.pop_front();
          if (m_axis_tuser !== rom_want.target || m_axis_tdata[21:0] !== rom_want.rom_address ||
              m_axis_tdata[23:22] !== rom_want.mirror_mode ||
              m_axis_tdata[24] !== rom_want.irq_line || m_axis_tdata[31:25] !== 7'h0) begin
            $display("%0t: mismatch expected tgt=%0d addr=%h mir=%0d irq=%b actual tgt=%0d addr=%h mir=%0d irq=%b pad=%h",
                     $time, rom_want.target, rom_want.rom_address, rom_want.mirror_mode,
                     rom_want.irq_line, m_axis_tuser, m_axis_tdata[21:0], m_axis_tdata[23:22],
                     m_axis_tdata[24], m_axis_tdata[31:25]);
            n_err++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_rdy = 1'b0;
      end else begin
        case (rx_cyc[7:6])
          2'd0: rx_rdy = 1'b1;
          2'd1: rx_rdy = ($urandom_range(3, 0) != 0);
          2'd2: rx_rdy = ($urandom_range(3, 0) == 0);
          default: rx_rdy = rx_cyc[1];
        endcase
      end
      m_axis_tready <= rx_rdy;
    end
  end

  // watchdog: no beat moving on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
    if (idle_cyc >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
